// File: sv/psc_pkg.sv
// shared types, constants and register codes for the pump safety cutoff
package psc_pkg;

	// timekeeping defaults and unit scaling
	localparam int TIME_BITS_DEF = 32;
	localparam int MS_PER_SEC    = 1000;
	localparam int MS_PER_MIN    = 60000;
	localparam int NEAR_NUM      = 9;
	localparam int NEAR_DEN      = 10;
	// 90 percent of a minute in ms, exact so no rounding is lost
	localparam int NEAR_MS_PER_MIN = MS_PER_MIN * NEAR_NUM / NEAR_DEN;

	// register field widths
	localparam int FLOW_W    = 16;
	localparam int DRY_SEC_W = 12;
	localparam int RUN_MIN_W = 11;
	localparam int MS_CFG_W  = 20;
	localparam int COUNT_W   = 16;
	localparam int STAMP_W   = 32;

	// widths of the scaled limits held in the config block
	localparam int DRY_MS_W = 22;
	localparam int RUN_MS_W = 27;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	// reset values
	localparam int BYPASS_RST    = 0;
	localparam int DRY_THR_RST   = 100;
	localparam int DRY_SEC_RST   = 30;
	localparam int RUN_MIN_RST   = 30;
	localparam int STUCK_THR_RST = 50;
	localparam int STUCK_MS_RST  = 10000;
	localparam int STALE_MS_RST  = 5000;

	localparam int DRY_MS_RST  = DRY_SEC_RST * MS_PER_SEC;
	localparam int MAX_MS_RST  = RUN_MIN_RST * MS_PER_MIN;
	localparam int NEAR_MS_RST = RUN_MIN_RST * NEAR_MS_PER_MIN;

	// stream widths
	localparam int IN_W        = 82;
	localparam int IN_TDATA_W  = 88;
	localparam int OUT_W       = 22;
	localparam int OUT_TDATA_W = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BYPASS    = 3'd0,
		REG_DRY_THR   = 3'd1,
		REG_DRY_SEC   = 3'd2,
		REG_RUN_MIN   = 3'd3,
		REG_STUCK_THR = 3'd4,
		REG_STUCK_MS  = 3'd5,
		REG_STALE_MS  = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		DEC_OK   = 2'd0,
		DEC_DRY  = 2'd1,
		DEC_OVER = 2'd2
	} decision_t;

	typedef struct packed {
		logic                bypass;
		logic [FLOW_W-1:0]   dry_thr;
		logic [DRY_MS_W-1:0] dry_ms;
		logic [RUN_MS_W-1:0] max_ms;
		logic [RUN_MS_W-1:0] near_ms;
		logic [FLOW_W-1:0]   stuck_thr;
		logic [MS_CFG_W-1:0] stuck_ms;
		logic [MS_CFG_W-1:0] stale_ms;
	} cfg_t;

	// last field in the lowest bits
	typedef struct packed {
		logic [STAMP_W-1:0] level_update_ms;
		logic               sensor_stable;
		logic [FLOW_W-1:0]  flow_rate;
		logic               pump_running;
		logic [STAMP_W-1:0] now_ms;
	} item_t;

	typedef struct packed {
		logic [COUNT_W-1:0] stuck_events;
		logic               overrun_error;
		logic               flow_error;
		logic               dry_run_error;
		logic               near_max_runtime;
		decision_t          decision;
	} result_t;

endpackage

// File: sv/psc_cfg.sv
// configuration registers with limits pre-scaled to milliseconds on write
module psc_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [psc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [psc_pkg::CFG_DATA_W-1:0]   cfg_data,
	output psc_pkg::cfg_t                    cfg
);

	psc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bypass    <= 1'(psc_pkg::BYPASS_RST);
			cfg_q.dry_thr   <= psc_pkg::FLOW_W'(psc_pkg::DRY_THR_RST);
			cfg_q.dry_ms    <= psc_pkg::DRY_MS_W'(psc_pkg::DRY_MS_RST);
			cfg_q.max_ms    <= psc_pkg::RUN_MS_W'(psc_pkg::MAX_MS_RST);
			cfg_q.near_ms   <= psc_pkg::RUN_MS_W'(psc_pkg::NEAR_MS_RST);
			cfg_q.stuck_thr <= psc_pkg::FLOW_W'(psc_pkg::STUCK_THR_RST);
			cfg_q.stuck_ms  <= psc_pkg::MS_CFG_W'(psc_pkg::STUCK_MS_RST);
			cfg_q.stale_ms  <= psc_pkg::MS_CFG_W'(psc_pkg::STALE_MS_RST);
		end else if (cfg_wr_en) begin
			unique case (psc_pkg::cfg_reg_t'(cfg_index))
				psc_pkg::REG_BYPASS: begin
					cfg_q.bypass <= cfg_data[0];
				end
				psc_pkg::REG_DRY_THR: begin
					cfg_q.dry_thr <= cfg_data[psc_pkg::FLOW_W-1:0];
				end
				psc_pkg::REG_DRY_SEC: begin
					cfg_q.dry_ms <= psc_pkg::DRY_MS_W'(cfg_data[psc_pkg::DRY_SEC_W-1:0])
						* psc_pkg::DRY_MS_W'(psc_pkg::MS_PER_SEC);
				end
				psc_pkg::REG_RUN_MIN: begin
					cfg_q.max_ms <= psc_pkg::RUN_MS_W'(cfg_data[psc_pkg::RUN_MIN_W-1:0])
						* psc_pkg::RUN_MS_W'(psc_pkg::MS_PER_MIN);
					cfg_q.near_ms <= psc_pkg::RUN_MS_W'(cfg_data[psc_pkg::RUN_MIN_W-1:0])
						* psc_pkg::RUN_MS_W'(psc_pkg::NEAR_MS_PER_MIN);
				end
				psc_pkg::REG_STUCK_THR: begin
					cfg_q.stuck_thr <= cfg_data[psc_pkg::FLOW_W-1:0];
				end
				psc_pkg::REG_STUCK_MS: begin
					cfg_q.stuck_ms <= cfg_data[psc_pkg::MS_CFG_W-1:0];
				end
				psc_pkg::REG_STALE_MS: begin
					cfg_q.stale_ms <= cfg_data[psc_pkg::MS_CFG_W-1:0];
				end
				default: begin
					// unused index, write dropped
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: sv/psc_eval.sv
// timer state and the single-pass safety evaluation of one item
module psc_eval #(
	parameter int TIME_BITS = psc_pkg::TIME_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  psc_pkg::cfg_t     cfg,
	input  psc_pkg::item_t    item,
	output psc_pkg::result_t  res
);

	// compare width covers both elapsed times and the scaled limits
	localparam int CW = (TIME_BITS > psc_pkg::RUN_MS_W) ? TIME_BITS : psc_pkg::RUN_MS_W;

	logic                       dry_on_q, dry_lat_q, stuck_on_q, fault_q, run_on_q, over_q;
	logic [TIME_BITS-1:0]       dry_start_q, stuck_start_q, run_start_q;
	logic [psc_pkg::COUNT_W-1:0] count_q;

	logic                       dry_on_d, dry_lat_d, stuck_on_d, fault_d, run_on_d, over_d;
	logic [TIME_BITS-1:0]       dry_start_d, stuck_start_d, run_start_d;
	logic [psc_pkg::COUNT_W-1:0] count_d;

	logic [TIME_BITS-1:0] t_now, t_lvl, el_lvl, el_dry, el_stuck, el_run;
	logic                 fresh, dry_stop, over_stop, near;

	assign t_now    = TIME_BITS'(item.now_ms);
	assign t_lvl    = TIME_BITS'(item.level_update_ms);
	assign el_lvl   = t_now - t_lvl;
	assign el_dry   = t_now - dry_start_q;
	assign el_stuck = t_now - stuck_start_q;
	assign el_run   = t_now - run_start_q;

	// a stamp of zero means the level was never reported
	assign fresh = (item.level_update_ms != '0) && (CW'(el_lvl) <= CW'(cfg.stale_ms));

	always_comb begin
		dry_on_d    = dry_on_q;
		dry_start_d = dry_start_q;
		dry_lat_d   = dry_lat_q;
		dry_stop    = 1'b0;
		if (cfg.bypass) begin
			dry_on_d    = 1'b0;
			dry_start_d = '0;
			dry_lat_d   = 1'b0;
		end else if (!item.pump_running || !item.sensor_stable || !fresh
				|| item.flow_rate >= cfg.dry_thr) begin
			dry_on_d    = 1'b0;
			dry_start_d = '0;
		end else if (!dry_on_q) begin
			dry_on_d    = 1'b1;
			dry_start_d = t_now;
		end else if (CW'(el_dry) >= CW'(cfg.dry_ms)) begin
			dry_lat_d = 1'b1;
			dry_stop  = 1'b1;
		end
	end

	always_comb begin
		stuck_on_d    = stuck_on_q;
		stuck_start_d = stuck_start_q;
		fault_d       = fault_q;
		count_d       = count_q;
		if (cfg.bypass) begin
			stuck_on_d    = 1'b0;
			stuck_start_d = '0;
			fault_d       = 1'b0;
		end else if (!item.pump_running && item.flow_rate > cfg.stuck_thr) begin
			if (!stuck_on_q) begin
				stuck_on_d    = 1'b1;
				stuck_start_d = t_now;
			end else if (CW'(el_stuck) >= CW'(cfg.stuck_ms) && !fault_q) begin
				fault_d = 1'b1;
				// event count sticks at full scale
				if (count_q != '1) begin
					count_d = count_q + psc_pkg::COUNT_W'(1);
				end
			end
		end else begin
			fault_d       = 1'b0;
			stuck_on_d    = 1'b0;
			stuck_start_d = '0;
		end
	end

	always_comb begin
		run_on_d    = run_on_q;
		run_start_d = run_start_q;
		over_d      = over_q;
		over_stop   = 1'b0;
		near        = 1'b0;
		if (!item.pump_running) begin
			run_on_d    = 1'b0;
			run_start_d = '0;
		end else if (!run_on_q) begin
			run_on_d    = 1'b1;
			run_start_d = t_now;
		end else begin
			near = CW'(el_run) >= CW'(cfg.near_ms);
			if (CW'(el_run) >= CW'(cfg.max_ms)) begin
				over_d    = 1'b1;
				run_on_d  = 1'b0;
				over_stop = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dry_on_q      <= 1'b0;
			dry_start_q   <= '0;
			dry_lat_q     <= 1'b0;
			stuck_on_q    <= 1'b0;
			stuck_start_q <= '0;
			fault_q       <= 1'b0;
			count_q       <= '0;
			run_on_q      <= 1'b0;
			run_start_q   <= '0;
			over_q        <= 1'b0;
		end else if (step) begin
			dry_on_q      <= dry_on_d;
			dry_start_q   <= dry_start_d;
			dry_lat_q     <= dry_lat_d;
			stuck_on_q    <= stuck_on_d;
			stuck_start_q <= stuck_start_d;
			fault_q       <= fault_d;
			count_q       <= count_d;
			run_on_q      <= run_on_d;
			run_start_q   <= run_start_d;
			over_q        <= over_d;
		end
	end

	always_comb begin
		if (dry_stop) begin
			res.decision = psc_pkg::DEC_DRY;
		end else if (over_stop) begin
			res.decision = psc_pkg::DEC_OVER;
		end else begin
			res.decision = psc_pkg::DEC_OK;
		end
		res.near_max_runtime = near;
		res.dry_run_error    = dry_lat_d;
		res.flow_error       = fault_d;
		res.overrun_error    = over_d;
		res.stuck_events     = count_d;
	end

endmodule

// File: sv/pump_safety_cutoff_unit.sv
// Pump safety cutoff: dry-run, stuck-high flow and max-runtime checks per beat.
// Path: a taken beat is captured in the input register, then its result in the
// result register. Throughput: one beat per clock unless m_tready stalls;
// the timer state updates in one pass.
// Reset: arst_n clears the timers, latches, event count and both valid flags
// and loads the default configuration.
module pump_safety_cutoff_unit #(
	parameter int TIME_BITS = psc_pkg::TIME_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// now_ms[31:0], pump_running[32], flow_rate[48:33], sensor_stable[49],
	// level_update_ms[81:50], zeros above
	input  logic [psc_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// decision[1:0], near_max_runtime[2], dry_run_error[3], flow_error[4],
	// overrun_error[5], stuck_events[21:6], zeros above
	output logic [psc_pkg::OUT_TDATA_W-1:0]    m_tdata,
	input  logic                               cfg_wr_en,
	input  logic [psc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [psc_pkg::CFG_DATA_W-1:0]     cfg_data
);

	psc_pkg::cfg_t    cfg;
	psc_pkg::item_t   item_s1;
	psc_pkg::result_t res_comb, res_s2;
	logic             valid_s1, valid_s2, advance;

	// result register free or draining this cycle
	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= psc_pkg::item_t'(s_tdata[psc_pkg::IN_W-1:0]);
		end
		if (valid_s1 && advance) begin
			res_s2 <= res_comb;
		end
	end

	psc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	psc_eval #(
		.TIME_BITS (TIME_BITS)
	) u_eval (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (valid_s1 && advance),
		.cfg    (cfg),
		.item   (item_s1),
		.res    (res_comb)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = psc_pkg::OUT_TDATA_W'(res_s2);

endmodule

// File: sv/psc_checker.sv
// port-level checks on the result stream of the pump safety cutoff
module psc_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [psc_pkg::OUT_TDATA_W-1:0] m_tdata
);

	logic over_seen_q;

	// overrun latch is only cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			over_seen_q <= 1'b0;
		end else if (m_tvalid && m_tready && m_tdata[5]) begin
			over_seen_q <= 1'b1;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat dropped or changed while stalled");

	a_dry_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] == psc_pkg::DEC_DRY |-> m_tdata[3])
		else $error("dry-run stop without dry-run error");

	a_over_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] == psc_pkg::DEC_OVER |-> m_tdata[5])
		else $error("overrun stop without overrun error");

	a_over_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && over_seen_q |-> m_tdata[5])
		else $error("overrun error cleared without reset");

endmodule

bind pump_safety_cutoff_unit psc_checker u_psc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// File: sim/tb_pump_safety_cutoff_unit.sv
// self-checking testbench for the pump safety cutoff unit: stream driver, monitor and predictor
`timescale 1ns / 100ps

module tb_pump_safety_cutoff_unit;

	localparam logic [psc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int N_PHASES    = 14;
	localparam int PER_PHASE   = 95;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE      = 8;

	typedef enum int {SCENE_DRY, SCENE_STUCK, SCENE_RUN, SCENE_NOISE} scene_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [psc_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [psc_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic                            cfg_wr_en = 1'b0;
	logic [psc_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
	logic [psc_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

	// predictor copy of the configuration
	logic                          c_bypass    = 1'(psc_pkg::BYPASS_RST);
	logic [psc_pkg::FLOW_W-1:0]    c_dry_thr   = psc_pkg::FLOW_W'(psc_pkg::DRY_THR_RST);
	logic [psc_pkg::DRY_SEC_W-1:0] c_dry_sec   = psc_pkg::DRY_SEC_W'(psc_pkg::DRY_SEC_RST);
	logic [psc_pkg::RUN_MIN_W-1:0] c_run_min   = psc_pkg::RUN_MIN_W'(psc_pkg::RUN_MIN_RST);
	logic [psc_pkg::FLOW_W-1:0]    c_stuck_thr = psc_pkg::FLOW_W'(psc_pkg::STUCK_THR_RST);
	logic [psc_pkg::MS_CFG_W-1:0]  c_stuck_ms  = psc_pkg::MS_CFG_W'(psc_pkg::STUCK_MS_RST);
	logic [psc_pkg::MS_CFG_W-1:0]  c_stale_ms  = psc_pkg::MS_CFG_W'(psc_pkg::STALE_MS_RST);

	// predictor copy of the timers and latches
	logic                        dry_on = 1'b0;
	logic [psc_pkg::STAMP_W-1:0] dry_t0 = '0;
	logic                        dry_lock = 1'b0;
	logic                        stuck_on = 1'b0;
	logic [psc_pkg::STAMP_W-1:0] stuck_t0 = '0;
	logic                        flow_fault = 1'b0;
	logic [psc_pkg::COUNT_W-1:0] stuck_cnt = '0;
	logic                        run_on = 1'b0;
	logic [psc_pkg::STAMP_W-1:0] run_t0 = '0;
	logic                        over_lock = 1'b0;

	psc_pkg::item_t   evals_pending[$];
	psc_pkg::result_t verdicts_due[$];
	logic [31:0]      sim_now = '0;
	bit               idle_en = 1'b1;
	bit               in_taken = 1'b0;
	int               src_gap = 0;
	int               sink_gap = 0;
	int               hold_left = 0;
	int               holds_asked = 0;
	int               holds_served = 0;
	int               mismatches = 0;

	pump_safety_cutoff_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic psc_pkg::result_t evaluate_safety(psc_pkg::item_t it);
		logic [31:0]      el;
		logic [63:0]      dry_lim, max_lim, near_lim;
		logic             fresh, dry_stop, over_stop, near;
		psc_pkg::result_t r;
		dry_stop = 1'b0;
		over_stop = 1'b0;
		near = 1'b0;
		dry_lim = c_dry_sec * psc_pkg::MS_PER_SEC;
		max_lim = c_run_min * psc_pkg::MS_PER_MIN;
		near_lim = max_lim * psc_pkg::NEAR_NUM / psc_pkg::NEAR_DEN;

		// dry-run timer
		if (c_bypass) begin
			dry_on = 1'b0;
			dry_t0 = '0;
			dry_lock = 1'b0;
		end else if (!it.pump_running) begin
			dry_on = 1'b0;
			dry_t0 = '0;
		end else begin
			el = it.now_ms - it.level_update_ms;
			fresh = (it.level_update_ms != 0) && (el <= c_stale_ms);
			if (!it.sensor_stable || !fresh) begin
				dry_on = 1'b0;
				dry_t0 = '0;
			end else if (it.flow_rate < c_dry_thr) begin
				el = it.now_ms - dry_t0;
				if (!dry_on) begin
					dry_on = 1'b1;
					dry_t0 = it.now_ms;
				end else if (el >= dry_lim) begin
					dry_lock = 1'b1;
					dry_stop = 1'b1;
				end
			end else begin
				dry_on = 1'b0;
				dry_t0 = '0;
			end
		end

		// stuck-high flow with the pump off
		if (c_bypass) begin
			stuck_on = 1'b0;
			stuck_t0 = '0;
			flow_fault = 1'b0;
		end else if (!it.pump_running && it.flow_rate > c_stuck_thr) begin
			el = it.now_ms - stuck_t0;
			if (!stuck_on) begin
				stuck_on = 1'b1;
				stuck_t0 = it.now_ms;
			end else if (el >= c_stuck_ms && !flow_fault) begin
				flow_fault = 1'b1;
				if (stuck_cnt != {psc_pkg::COUNT_W{1'b1}})
					stuck_cnt = stuck_cnt + psc_pkg::COUNT_W'(1);
			end
		end else begin
			flow_fault = 1'b0;
			stuck_on = 1'b0;
			stuck_t0 = '0;
		end

		// continuous run time
		if (!it.pump_running) begin
			run_on = 1'b0;
			run_t0 = '0;
		end else if (!run_on) begin
			run_on = 1'b1;
			run_t0 = it.now_ms;
		end else begin
			el = it.now_ms - run_t0;
			near = el >= near_lim;
			if (el >= max_lim) begin
				over_lock = 1'b1;
				run_on = 1'b0;
				over_stop = 1'b1;
			end
		end

		if (dry_stop)
			r.decision = psc_pkg::DEC_DRY;
		else if (over_stop)
			r.decision = psc_pkg::DEC_OVER;
		else
			r.decision = psc_pkg::DEC_OK;
		r.near_max_runtime = near;
		r.dry_run_error = dry_lock;
		r.flow_error = flow_fault;
		r.overrun_error = over_lock;
		r.stuck_events = stuck_cnt;
		return r;
	endfunction

	task automatic check_field(string field, int want, int got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
		end
	endtask

	// input driver, new beat or gap chosen at the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || in_taken) begin
				if (in_taken && idle_en && src_gap == 0 && $urandom_range(0, 4) == 0)
					src_gap = $urandom_range(1, 14);
				if (src_gap != 0) begin
					src_gap--;
					s_tvalid <= 1'b0;
				end else if (evals_pending.size() != 0) begin
					s_tdata <= {{(psc_pkg::IN_TDATA_W-psc_pkg::IN_W){1'b0}},
						evals_pending.pop_front()};
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result sink, with random stalls and the long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (holds_asked != holds_served) begin
				holds_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (sink_gap != 0) begin
				sink_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (idle_en && $urandom_range(0, 4) == 0)
					sink_gap = $urandom_range(1, 14);
			end
		end
	end

	// both handshakes sampled at the rising edge
	always @(posedge clk) begin
		psc_pkg::result_t seen, want;
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= s_tvalid && s_tready;
			if (s_tvalid && s_tready)
				verdicts_due.push_back(evaluate_safety(
					psc_pkg::item_t'(s_tdata[psc_pkg::IN_W-1:0])));
			if (m_tvalid && m_tready) begin
				seen = psc_pkg::result_t'(m_tdata[psc_pkg::OUT_W-1:0]);
				if (verdicts_due.size() == 0) begin
					mismatches++;
					$display("%0t: result beat with nothing expected, expected none, got %h",
						$time, m_tdata);
				end else begin
					want = verdicts_due.pop_front();
					check_field("decision", want.decision, seen.decision);
					check_field("near_max_runtime", want.near_max_runtime, seen.near_max_runtime);
					check_field("dry_run_error", want.dry_run_error, seen.dry_run_error);
					check_field("flow_error", want.flow_error, seen.flow_error);
					check_field("overrun_error", want.overrun_error, seen.overrun_error);
					check_field("stuck_events", want.stuck_events, seen.stuck_events);
				end
			end
		end
	end

	task automatic push_eval(logic [31:0] t, bit run, logic [15:0] flow, bit stab,
			logic [31:0] lvl);
		psc_pkg::item_t it;
		it.now_ms = t;
		it.pump_running = run;
		it.flow_rate = flow;
		it.sensor_stable = stab;
		it.level_update_ms = lvl;
		evals_pending.push_back(it);
	endtask

	task automatic write_reg(logic [psc_pkg::CFG_IDX_W-1:0] idx,
			logic [psc_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			psc_pkg::REG_BYPASS:    c_bypass = val[0];
			psc_pkg::REG_DRY_THR:   c_dry_thr = val[psc_pkg::FLOW_W-1:0];
			psc_pkg::REG_DRY_SEC:   c_dry_sec = val[psc_pkg::DRY_SEC_W-1:0];
			psc_pkg::REG_RUN_MIN:   c_run_min = val[psc_pkg::RUN_MIN_W-1:0];
			psc_pkg::REG_STUCK_THR: c_stuck_thr = val[psc_pkg::FLOW_W-1:0];
			psc_pkg::REG_STUCK_MS:  c_stuck_ms = val;
			psc_pkg::REG_STALE_MS:  c_stale_ms = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic apply_config(bit byp, int dthr, int dsec, int rmin, int sthr, int sms,
			int stale);
		write_reg(psc_pkg::REG_BYPASS, psc_pkg::CFG_DATA_W'(byp));
		write_reg(psc_pkg::REG_DRY_THR, psc_pkg::CFG_DATA_W'(dthr));
		write_reg(psc_pkg::REG_DRY_SEC, psc_pkg::CFG_DATA_W'(dsec));
		write_reg(psc_pkg::REG_RUN_MIN, psc_pkg::CFG_DATA_W'(rmin));
		write_reg(psc_pkg::REG_STUCK_THR, psc_pkg::CFG_DATA_W'(sthr));
		write_reg(psc_pkg::REG_STUCK_MS, psc_pkg::CFG_DATA_W'(sms));
		write_reg(psc_pkg::REG_STALE_MS, psc_pkg::CFG_DATA_W'(stale));
		// an index with no register behind it must change nothing
		write_reg(REG_UNUSED, psc_pkg::CFG_DATA_W'($urandom));
	endtask

	task automatic wait_idle();
		@(posedge clk);
		while (evals_pending.size() != 0 || s_tvalid || verdicts_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// timed sequences aimed at one timer at a time, plus noise
	task automatic queue_phase(int count);
		scene_t      scene;
		int          seg, span;
		logic [31:0] step, lvl;
		logic [15:0] flow;
		bit          run, stab;
		while (count > 0) begin
			scene = scene_t'($urandom_range(0, 3));
			seg = $urandom_range(4, 20);
			case (scene)
				SCENE_DRY:   span = c_dry_sec * psc_pkg::MS_PER_SEC;
				SCENE_STUCK: span = c_stuck_ms;
				SCENE_RUN:   span = c_run_min * psc_pkg::MS_PER_MIN;
				default:     span = $urandom_range(0, 100000);
			endcase
			if ($urandom_range(0, 7) == 0)
				sim_now = 32'hFFFF_FFFF - $urandom_range(0, span);
			for (int k = 0; k < seg && count > 0; k++) begin
				case ($urandom_range(0, 15))
					0:       step = 0;
					1:       step = $urandom;
					default: step = $urandom_range(0, span / 3 + 1);
				endcase
				sim_now = sim_now + step;
				case (scene)
					SCENE_STUCK: run = ($urandom_range(0, 15) == 0);
					SCENE_NOISE: run = $urandom_range(0, 1);
					default:     run = ($urandom_range(0, 15) != 0);
				endcase
				flow = $urandom_range(0, 65535);
				if (scene == SCENE_DRY && $urandom_range(0, 7) != 0)
					flow = (c_dry_thr == 0) ? 16'd0 : $urandom_range(0, c_dry_thr - 1);
				if (scene == SCENE_STUCK && $urandom_range(0, 7) != 0)
					flow = (c_stuck_thr == 16'hFFFF) ? 16'hFFFF :
						$urandom_range(c_stuck_thr + 1, 65535);
				stab = (scene == SCENE_NOISE) ? $urandom_range(0, 1) : ($urandom_range(0, 15) != 0);
				case ($urandom_range(0, 15))
					0:       lvl = 0;
					1:       lvl = $urandom;
					2:       lvl = sim_now - c_stale_ms - $urandom_range(1, 1000);
					3:       lvl = sim_now - c_stale_ms;
					default: lvl = sim_now - $urandom_range(0, c_stale_ms);
				endcase
				push_eval(sim_now, run, flow, stab, lvl);
				count--;
			end
		end
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// directed beats at the reset configuration
		push_eval(32'd1000, 1, 16'd0, 1, 32'd1000);
		push_eval(32'd31000, 1, 16'd0, 1, 32'd30000);
		push_eval(32'd31500, 1, 16'hFFFF, 1, 32'd31500);
		push_eval(32'd1801000, 1, 16'hFFFF, 1, 32'd1801000);
		push_eval(32'd1801001, 1, 16'd200, 1, 32'd1801001);
		push_eval(32'd3421001, 1, 16'd200, 1, 32'd3421001);
		push_eval(32'd4000000, 0, 16'hFFFF, 1, 32'd0);
		push_eval(32'd4010000, 0, 16'hFFFF, 1, 32'd0);
		push_eval(32'd4020000, 0, 16'hFFFF, 0, 32'd0);
		push_eval(32'd4020001, 0, 16'd50, 0, 32'd0);
		// stuck timer across the time wrap
		push_eval(32'hFFFF_F000, 0, 16'd51, 1, 32'd0);
		push_eval(32'h0000_1800, 0, 16'd51, 1, 32'd0);
		// level freshness gates
		push_eval(32'h0000_2000, 1, 16'd0, 0, 32'h0000_2000);
		push_eval(32'h0000_2001, 1, 16'd0, 1, 32'd0);
		push_eval(32'h0000_2002, 1, 16'd0, 1, 32'h0000_2002 - 32'd5001);
		push_eval(32'h0000_2003, 1, 16'd0, 1, 32'h0000_2003 - 32'd5000);
		// dry and overrun on the same beat, dry wins
		push_eval(32'hFFFF_FFFF, 1, 16'd99, 1, 32'hFFFF_FFFF);
		push_eval(32'd0, 1, 16'd100, 1, 32'hFFFF_FFF0);
		push_eval(32'd1, 0, 16'd0, 0, 32'hAAAA_5555);

		for (int p = 0; p < N_PHASES; p++) begin
			wait_idle();
			case (p)
				0: apply_config(0, 0, 0, 0, 0, 0, 0);
				1: apply_config(1, 65535, 3600, 1440, 65535, 600000, 600000);
				2: apply_config(0, 65535, 3600, 1440, 65535, 600000, 600000);
				default: apply_config($urandom_range(0, 3) == 0, $urandom_range(0, 65535),
					($urandom_range(0, 3) == 0) ? $urandom_range(0, 3600) : $urandom_range(0, 5),
					($urandom_range(0, 3) == 0) ? $urandom_range(0, 1440) : $urandom_range(0, 3),
					$urandom_range(0, 65535),
					($urandom_range(0, 3) == 0) ? $urandom_range(0, 600000) : $urandom_range(0, 3000),
					($urandom_range(0, 3) == 0) ? $urandom_range(0, 600000) : $urandom_range(0, 10000));
			endcase
			idle_en = (p % 4 != 3) && (p < N_PHASES - 2);
			queue_phase(PER_PHASE);
			// sink holds off while the source keeps offering, so the unit backs up
			if (p == 3)
				holds_asked++;
		end
		wait_idle();

		if (mismatches == 0)
			$display("tb_pump_safety_cutoff_unit: PASS");
		else
			$display("tb_pump_safety_cutoff_unit: FAIL");
		$finish;
	end

	initial begin
		#500000;
		$display("tb_pump_safety_cutoff_unit: FAIL");
		$finish;
	end

endmodule
